// ===== src/adam_optimizer_update_core_macros.svh =====
// assertion macros for the adam update core
// used by the front end and back end modules, needs clk_i and rst_ni in scope
`ifndef ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define AOUC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define AOUC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define AOUC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/aouc_pkg.sv =====
// shared types, constants and helper functions for the adam update core
// no dependencies
package aouc_pkg;

  localparam int MaxWeights = 64;
  localparam int NumSlots   = MaxWeights + 1;
  localparam int SlotW      = 7;
  localparam int AddrW      = $clog2(NumSlots);
  localparam int QueueDepth = 2;
  localparam int EntryW     = 96;
  localparam int SqrtSteps  = 28;
  localparam int DivSteps   = 32;

  localparam logic [1:0] CfgLearningRate = 2'd0;
  localparam logic [1:0] CfgBetaOne      = 2'd1;
  localparam logic [1:0] CfgBetaTwo      = 2'd2;
  localparam logic [1:0] CfgEpsilon      = 2'd3;

  localparam logic [30:0] LrReset  = 31'd167772;
  localparam logic [15:0] B1Reset  = 16'd58982;
  localparam logic [15:0] B2Reset  = 16'd64881;
  localparam logic [15:0] EpsReset = 16'd1;

  localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

  typedef struct packed {
    logic              cmd;
    logic [SlotW-1:0]  slot_index;
    logic signed [31:0] operand_value;
    logic              new_step;
  } aouc_in_t;

  typedef struct packed {
    logic [SlotW-1:0]   result_index;
    logic signed [31:0] updated_weight;
  } aouc_out_t;

  typedef struct packed {
    logic [30:0] learning_rate;
    logic [15:0] beta_one;
    logic [15:0] beta_two;
    logic [15:0] epsilon_term;
  } aouc_cfg_t;

  typedef struct packed {
    logic               is_load;
    logic [SlotW-1:0]   slot;
    logic signed [31:0] operand;
    logic               new_step;
  } aouc_job_t;

  typedef struct packed {
    logic        start;
    logic [32:0] hi;
    logic [31:0] lo;
    logic [32:0] divisor;
  } aouc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } aouc_div_rsp_t;

  // clamp a quotient magnitude to the signed 32-bit range
  function automatic logic [31:0] sat_mag(input logic neg, input logic [31:0] q);
    logic [31:0] r;
    if (neg) begin
      r = (q > 32'h8000_0000) ? 32'h8000_0000 : q;
    end else begin
      r = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // w minus signed step, saturated
  function automatic logic [31:0] sub_sat(input logic [31:0] w, input logic neg,
                                          input logic [31:0] mag);
    logic signed [33:0] s;
    logic signed [33:0] d;
    logic [31:0]        r;
    s = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    d = $signed({{2{w[31]}}, w}) - s;
    if (d > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (d < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/adam_optimizer_update_core.sv =====
// adam weight update core: config registers, front end queue and back end sequencer
// depends on aouc_pkg, aouc_front, aouc_back
//
//  port      | dir | word            | handshake
//  in_*      | in  | aouc_in_t       | valid/stall, stall driven here
//  out_*     | out | aouc_out_t      | valid/stall, stall driven by sink
//  cfg_*     | in  | index + data    | write enable, no wait
//
// a load word writes its operand into the slot with zeroed moments; an update word
// may run two divisions for the bias corrections, a 28-step square root and a
// third division for the step, and the three divisions share one divider.
// the slot store needs no clearing pass, per-slot valid flops reset at once.
// a two-entry queue and the output register let both sides stall independently.
module adam_optimizer_update_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aouc_pkg::aouc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aouc_pkg::aouc_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i
);

  aouc_pkg::aouc_cfg_t cfg_q, cfg_d;
  aouc_pkg::aouc_job_t job;
  logic                job_valid, job_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        aouc_pkg::CfgLearningRate: cfg_d.learning_rate = cfg_data_i;
        aouc_pkg::CfgBetaOne:      cfg_d.beta_one      = cfg_data_i[15:0];
        aouc_pkg::CfgBetaTwo:      cfg_d.beta_two      = cfg_data_i[15:0];
        aouc_pkg::CfgEpsilon:      cfg_d.epsilon_term  = cfg_data_i[15:0];
        default:                   cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= aouc_pkg::LrReset;
      cfg_q.beta_one      <= aouc_pkg::B1Reset;
      cfg_q.beta_two      <= aouc_pkg::B2Reset;
      cfg_q.epsilon_term  <= aouc_pkg::EpsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  aouc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  aouc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/aouc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module aouc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/aouc_front.sv =====
// front end: accepts items, clamps the slot, queues jobs for the back end
// depends on aouc_pkg and the macros header
`include "adam_optimizer_update_core_macros.svh"

module aouc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  aouc_pkg::aouc_in_t   in_data_i,
  output logic                 job_valid_o,
  output aouc_pkg::aouc_job_t  job_o,
  input  logic                 job_pop_i
);

  localparam int PtrW = $clog2(aouc_pkg::QueueDepth);
  localparam int CntW = $clog2(aouc_pkg::QueueDepth + 1);
  localparam logic [aouc_pkg::SlotW-1:0] MaxSlot = aouc_pkg::SlotW'(aouc_pkg::MaxWeights);
  localparam logic [CntW-1:0] Full = CntW'(aouc_pkg::QueueDepth);

  aouc_pkg::aouc_job_t entries_q [aouc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  aouc_pkg::aouc_job_t job_in;
  logic push;

  always_comb begin
    job_in.is_load  = in_data_i.cmd;
    job_in.slot     = (in_data_i.slot_index > MaxSlot) ? MaxSlot : in_data_i.slot_index;
    job_in.operand  = in_data_i.operand_value;
    job_in.new_step = in_data_i.new_step;
  end

  assign in_stall_o  = (cnt_q == Full);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(aouc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (job_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(aouc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !job_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && job_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= job_in;
    end
  end

  `AOUC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= Full, "queue count above depth")
  `AOUC_ASSERT_IMPL(a_pop_nonempty, job_pop_i, cnt_q != '0, "pop from empty queue")

endmodule

// ===== src/aouc_div.sv =====
// shared restoring divider, one quotient bit per cycle
// quotient of {hi, lo} by divisor, hi must be below divisor; depends on aouc_pkg
module aouc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aouc_pkg::aouc_div_req_t req_i,
  output aouc_pkg::aouc_div_rsp_t rsp_o
);

  localparam int CntW = $clog2(aouc_pkg::DivSteps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     quot_q, quot_d;
  logic [32:0]     div_q, div_d;
  logic [33:0]     trial;
  logic            ge;

  assign trial = {rem_q, quot_q[31]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(aouc_pkg::DivSteps - 1);
      rem_d  = req_i.hi;
      quot_d = req_i.lo;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? 33'(trial - {1'b0, div_q}) : trial[32:0];
      quot_d = {quot_q[30:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== src/aouc_back.sv =====
// back end: sequencer for weight loads and adam updates, slot store, output word
// depends on aouc_pkg, aouc_ram, aouc_div and the macros header
`include "adam_optimizer_update_core_macros.svh"

module aouc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aouc_pkg::aouc_cfg_t  cfg_i,
  input  logic                 job_valid_i,
  input  aouc_pkg::aouc_job_t  job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output aouc_pkg::aouc_out_t  out_data_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PWR1   = 5'd1;
  localparam logic [4:0] S_PWR2   = 5'd2;
  localparam logic [4:0] S_M1     = 5'd3;
  localparam logic [4:0] S_M2     = 5'd4;
  localparam logic [4:0] S_M3     = 5'd5;
  localparam logic [4:0] S_V1     = 5'd6;
  localparam logic [4:0] S_V2     = 5'd7;
  localparam logic [4:0] S_V3     = 5'd8;
  localparam logic [4:0] S_MSTART = 5'd9;
  localparam logic [4:0] S_MWAIT  = 5'd10;
  localparam logic [4:0] S_VSTART = 5'd11;
  localparam logic [4:0] S_VWAIT  = 5'd12;
  localparam logic [4:0] S_QINIT  = 5'd13;
  localparam logic [4:0] S_SQRT   = 5'd14;
  localparam logic [4:0] S_SMUL   = 5'd15;
  localparam logic [4:0] S_SSTART = 5'd16;
  localparam logic [4:0] S_SWAIT  = 5'd17;
  localparam logic [4:0] S_WUPD   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  localparam int SqCntW = $clog2(aouc_pkg::SqrtSteps);

  logic [4:0]                   state_q, state_d;
  aouc_pkg::aouc_job_t          job_q, job_d;
  logic [aouc_pkg::NumSlots-1:0] valid_q, valid_d;
  logic [32:0]                  p1_q, p1_d, p2_q, p2_d;
  logic signed [31:0]           w_q, w_d, m_q, m_d;
  logic [30:0]                  v_q, v_d;
  logic signed [49:0]           acc_q, acc_d;
  logic [57:0]                  accv_q, accv_d;
  logic [39:0]                  gsq_q, gsq_d;
  logic [31:0]                  mnew_q, mnew_d;
  logic [30:0]                  vnew_q, vnew_d;
  logic                         mneg_q, mneg_d;
  logic [31:0]                  mmag_q, mmag_d;
  logic [30:0]                  vmag_q, vmag_d;
  logic [55:0]                  x_q, x_d;
  logic [30:0]                  rem_q, rem_d;
  logic [27:0]                  root_q, root_d;
  logic [SqCntW-1:0]            cnt_q, cnt_d;
  logic [62:0]                  prod_q, prod_d;
  logic [28:0]                  denom_q, denom_d;
  logic [31:0]                  smag_q, smag_d;
  logic [31:0]                  wnew_q, wnew_d;
  logic                         out_valid_q, out_valid_d;
  aouc_pkg::aouc_out_t          out_q, out_d;

  logic                         ram_we, ram_re;
  logic [aouc_pkg::EntryW-1:0]  ram_wdata, ram_rdata;
  aouc_pkg::aouc_div_req_t      div_req;
  aouc_pkg::aouc_div_rsp_t      div_rsp;

  logic [48:0]        pow1_full, pow2_full;
  logic signed [48:0] mul_m1;
  logic signed [49:0] mul_m2;
  logic [16:0]        omb1, omb2;
  logic [31:0]        gmag, mabs;
  logic [63:0]        gsq_full;
  logic [46:0]        mul_v1;
  logic [56:0]        mul_v2;
  logic [32:0]        corr1, corr2;
  logic [30:0]        r4, trial;
  logic               sq_ge;
  logic [31:0]        wclip;
  logic [31:0]        vquot;

  assign omb1      = 17'h1_0000 - {1'b0, cfg_i.beta_one};
  assign omb2      = 17'h1_0000 - {1'b0, cfg_i.beta_two};
  assign pow1_full = p1_q * cfg_i.beta_one;
  assign pow2_full = p2_q * cfg_i.beta_two;
  assign mul_m1    = $signed({1'b0, cfg_i.beta_one}) * m_q;
  assign mul_m2    = $signed({1'b0, omb1}) * $signed(job_q.operand);
  assign gmag      = aouc_pkg::abs32(job_q.operand);
  assign gsq_full  = gmag * gmag;
  assign mul_v1    = cfg_i.beta_two * v_q;
  assign mul_v2    = omb2 * gsq_q;
  assign mabs      = aouc_pkg::abs32(mnew_q);
  assign corr1     = aouc_pkg::OneQ32 - p1_q;
  assign corr2     = aouc_pkg::OneQ32 - p2_q;
  assign r4        = {rem_q[28:0], x_q[55:54]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign sq_ge     = r4 >= trial;
  assign wclip     = aouc_pkg::sub_sat(w_q, mneg_q, smag_q);
  assign vquot     = aouc_pkg::sat_mag(1'b0, div_rsp.quot);

  aouc_ram #(
    .Width (aouc_pkg::EntryW),
    .Depth (aouc_pkg::NumSlots)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (aouc_pkg::AddrW'(job_q.slot)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (aouc_pkg::AddrW'(job_i.slot)),
    .rdata_o (ram_rdata)
  );

  aouc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    valid_d     = valid_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    w_d         = w_q;
    m_d         = m_q;
    v_d         = v_q;
    acc_d       = acc_q;
    accv_d      = accv_q;
    gsq_d       = gsq_q;
    mnew_d      = mnew_q;
    vnew_d      = vnew_q;
    mneg_d      = mneg_q;
    mmag_d      = mmag_q;
    vmag_d      = vmag_q;
    x_d         = x_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    denom_d     = denom_q;
    smag_d      = smag_q;
    wnew_d      = wnew_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    job_pop_o   = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = {wclip, mnew_q, 1'b0, vnew_q};
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          ram_re    = 1'b1;
          job_d     = job_i;
          state_d   = S_PWR1;
        end
      end
      S_PWR1: begin
        if (valid_q[job_q.slot]) begin
          w_d = $signed(ram_rdata[95:64]);
          m_d = $signed(ram_rdata[63:32]);
          v_d = ram_rdata[30:0];
        end else begin
          w_d = '0;
          m_d = '0;
          v_d = '0;
        end
        if (job_q.new_step) begin
          p1_d = pow1_full[48:16];
        end
        state_d = S_PWR2;
      end
      S_PWR2: begin
        if (job_q.new_step) begin
          p2_d = pow2_full[48:16];
        end
        if (job_q.is_load) begin
          ram_we             = 1'b1;
          ram_wdata          = {job_q.operand, 64'd0};
          valid_d[job_q.slot] = 1'b1;
          wnew_d             = job_q.operand;
          state_d            = S_DONE;
        end else begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        acc_d   = {mul_m1[48], mul_m1};
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q + mul_m2;
        state_d = S_M3;
      end
      S_M3: begin
        mnew_d  = acc_q[47:16];
        gsq_d   = gsq_full[63:24];
        state_d = S_V1;
      end
      S_V1: begin
        accv_d  = {11'd0, mul_v1};
        state_d = S_V2;
      end
      S_V2: begin
        accv_d  = accv_q + {1'b0, mul_v2};
        state_d = S_V3;
      end
      S_V3: begin
        vnew_d  = (accv_q[57:47] != '0) ? 31'h7FFF_FFFF : accv_q[46:16];
        state_d = S_MSTART;
      end
      S_MSTART: begin
        mneg_d = mnew_q[31];
        if (corr1 == '0) begin
          mmag_d  = mabs;
          state_d = S_VSTART;
        end else if ({1'b0, mabs} >= corr1) begin
          mmag_d  = aouc_pkg::sat_mag(mnew_q[31], 32'hFFFF_FFFF);
          state_d = S_VSTART;
        end else begin
          div_req.start   = 1'b1;
          div_req.hi      = {1'b0, mabs};
          div_req.lo      = '0;
          div_req.divisor = corr1;
          state_d         = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (div_rsp.done) begin
          mmag_d  = aouc_pkg::sat_mag(mneg_q, div_rsp.quot);
          state_d = S_VSTART;
        end
      end
      S_VSTART: begin
        if (corr2 == '0) begin
          vmag_d  = vnew_q;
          state_d = S_QINIT;
        end else if ({2'b00, vnew_q} >= corr2) begin
          vmag_d  = 31'h7FFF_FFFF;
          state_d = S_QINIT;
        end else begin
          div_req.start   = 1'b1;
          div_req.hi      = {2'b00, vnew_q};
          div_req.lo      = '0;
          div_req.divisor = corr2;
          state_d         = S_VWAIT;
        end
      end
      S_VWAIT: begin
        if (div_rsp.done) begin
          vmag_d  = vquot[30:0];
          state_d = S_QINIT;
        end
      end
      S_QINIT: begin
        x_d     = {1'b0, vmag_q, 24'd0};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = SqCntW'(aouc_pkg::SqrtSteps - 1);
        state_d = S_SQRT;
      end
      S_SQRT: begin
        rem_d  = sq_ge ? (r4 - trial) : r4;
        root_d = {root_q[26:0], sq_ge};
        x_d    = {x_q[53:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SMUL;
        end
      end
      S_SMUL: begin
        prod_d  = cfg_i.learning_rate * mmag_q;
        denom_d = {1'b0, root_q} + {13'd0, cfg_i.epsilon_term};
        state_d = S_SSTART;
      end
      S_SSTART: begin
        if (denom_q == '0) begin
          smag_d  = '0;
          state_d = S_WUPD;
        end else if (prod_q[62:32] >= {2'b00, denom_q}) begin
          smag_d  = aouc_pkg::sat_mag(mneg_q, 32'hFFFF_FFFF);
          state_d = S_WUPD;
        end else begin
          div_req.start   = 1'b1;
          div_req.hi      = {2'b00, prod_q[62:32]};
          div_req.lo      = prod_q[31:0];
          div_req.divisor = {4'd0, denom_q};
          state_d         = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (div_rsp.done) begin
          smag_d  = aouc_pkg::sat_mag(mneg_q, div_rsp.quot);
          state_d = S_WUPD;
        end
      end
      S_WUPD: begin
        ram_we              = 1'b1;
        valid_d[job_q.slot] = 1'b1;
        wnew_d              = wclip;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.result_index   = job_q.slot;
          out_d.updated_weight = wnew_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      p1_q        <= aouc_pkg::OneQ32;
      p2_q        <= aouc_pkg::OneQ32;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    w_q     <= w_d;
    m_q     <= m_d;
    v_q     <= v_d;
    acc_q   <= acc_d;
    accv_q  <= accv_d;
    gsq_q   <= gsq_d;
    mnew_q  <= mnew_d;
    vnew_q  <= vnew_d;
    mneg_q  <= mneg_d;
    mmag_q  <= mmag_d;
    vmag_q  <= vmag_d;
    x_q     <= x_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    prod_q  <= prod_d;
    denom_q <= denom_d;
    smag_q  <= smag_d;
    wnew_q  <= wnew_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AOUC_ASSERT_NEXT(a_div_wait, div_req.start,
    state_q == S_MWAIT || state_q == S_VWAIT || state_q == S_SWAIT, "divider started without wait")
  `AOUC_ASSERT_IMPL(a_store_write, ram_we,
    state_q == S_PWR2 || state_q == S_WUPD, "slot store written outside write states")
  `AOUC_ASSERT_IMPL(a_pop_idle, job_pop_o, state_q == S_IDLE, "job taken while busy")

endmodule
